// ===== design/wst_pkg.sv =====
package wst_pkg;

  localparam int MAX_WAVES = 16;
  localparam int NUM_CH    = 2;
  localparam int IDX_W     = $clog2(MAX_WAVES);
  localparam int CH_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int CNT_W     = $clog2(MAX_WAVES + 1);
  localparam int ADDR_W    = CH_W + IDX_W;
  localparam int DEPTH     = NUM_CH * MAX_WAVES;

  localparam int REQ_W  = 4;
  localparam int WID_W  = 5;
  localparam int CHIN_W = 2;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 3;
  localparam int IDO_W  = 4;
  localparam int CNTO_W = 5;

  localparam logic [REQ_W-1:0] REQ_ADD      = 4'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY   = 4'd2;
  localparam logic [REQ_W-1:0] REQ_SET_FREQ = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SET_AMP  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_SET_PH   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_READ     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_COUNT    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_RST_CH   = 4'd8;
  localparam logic [REQ_W-1:0] REQ_RST_ALL  = 4'd9;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_CH = 3'd1;
  localparam logic [ST_W-1:0] ST_NEG    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_ID = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SHIFT_CHK, S_SHIFT_RD, S_SHIFT_WR, S_RESULT, S_OUT
  } state_t;

  typedef struct packed {
    logic take_req;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic remove_go;
    logic shift_more;
  } stat_t;

endpackage

// ===== design/wst_ctrl.sv =====
module wst_ctrl import wst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC:      state_next = stat.remove_go ? S_SHIFT_CHK : S_RESULT;
      S_SHIFT_CHK: state_next = stat.shift_more ? S_SHIFT_RD : S_RESULT;
      S_SHIFT_RD:  state_next = S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_CHK;
      S_RESULT:    state_next = S_OUT;
      S_OUT:       if (out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.take_req = in_valid;
      end
      S_EXEC:     cmd.exec     = 1'b1;
      S_SHIFT_RD: cmd.shift_rd = 1'b1;
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_RESULT:   cmd.load_res = 1'b1;
      S_OUT:      out_valid    = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/wst_dp.sv =====
module wst_dp import wst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [WID_W-1:0]  wave_id,
  input  logic [CHIN_W-1:0] channel,
  input  logic [VAL_W-1:0]  freq_in,
  input  logic [VAL_W-1:0]  amp_in,
  input  logic [VAL_W-1:0]  phase_in,
  output logic [ST_W-1:0]   status,
  output logic [IDO_W-1:0]  id_out,
  output logic [VAL_W-1:0]  freq_out,
  output logic [VAL_W-1:0]  amp_out,
  output logic [VAL_W-1:0]  phase_out,
  output logic [CNTO_W-1:0] wave_count
);

  // latched request
  logic [REQ_W-1:0]  r_req;
  logic [WID_W-1:0]  r_id;
  logic [CHIN_W-1:0] r_ch;
  logic [VAL_W-1:0]  r_f, r_a, r_p;

  // id map and counts
  logic              map_v   [MAX_WAVES];
  logic [CH_W-1:0]   map_ch  [MAX_WAVES];
  logic [IDX_W-1:0]  map_idx [MAX_WAVES];
  logic [CNT_W-1:0]  cnt     [NUM_CH];

  // parameter store, one array per field
  logic [VAL_W-1:0]  mem_f [DEPTH];
  logic [VAL_W-1:0]  mem_a [DEPTH];
  logic [VAL_W-1:0]  mem_p [DEPTH];
  logic [VAL_W-1:0]  rd_f, rd_a, rd_p;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we_f, we_a, we_p;
  logic [VAL_W-1:0]  wd_f, wd_a, wd_p;

  // removal walk
  logic [CH_W-1:0]   sh_c;
  logic [IDX_W-1:0]  sh_k;
  logic [CNT_W-1:0]  sh_n;

  // result holding
  logic [ST_W-1:0]   res_st;
  logic [IDO_W-1:0]  res_id;
  logic [CNTO_W-1:0] res_cnt;
  logic              res_rd;

  logic [IDX_W-1:0]  id_ix, free_id, loc_idx;
  logic [CH_W-1:0]   ch_ix, loc_ch;
  logic              id_ok, ch_ok, neg, full, free_found;
  logic [CNT_W:0]    total;
  logic [CNT_W-1:0]  n_ch, n_rm;
  logic [ST_W-1:0]   st_c;

  assign id_ix   = r_id[IDX_W-1:0];
  assign ch_ix   = r_ch[CH_W-1:0];
  assign id_ok   = ({1'b0, r_id} < (WID_W+1)'(MAX_WAVES)) && map_v[id_ix];
  assign ch_ok   = {1'b0, r_ch} < (CHIN_W+1)'(NUM_CH);
  assign neg     = r_f[VAL_W-1] | r_p[VAL_W-1];
  assign loc_ch  = map_ch[id_ix];
  assign loc_idx = map_idx[id_ix];
  assign n_ch    = cnt[ch_ix];
  assign n_rm    = (cnt[loc_ch] != '0) ? cnt[loc_ch] - 1'b1 : '0;

  always_comb begin
    free_id    = '0;
    free_found = 1'b0;
    for (int i = MAX_WAVES - 1; i >= 0; i--) begin
      if (!map_v[i]) begin
        free_id    = IDX_W'(i);
        free_found = 1'b1;
      end
    end
    total = '0;
    for (int c = 0; c < NUM_CH; c++) total = total + (CNT_W+1)'(cnt[c]);
    full = (total >= (CNT_W+1)'(MAX_WAVES)) || !free_found;
  end

  always_comb begin
    st_c = ST_OK;
    case (r_req)
      REQ_ADD: begin
        if (!ch_ok)    st_c = ST_BAD_CH;
        else if (neg)  st_c = ST_NEG;
        else if (full) st_c = ST_FULL;
      end
      REQ_REMOVE, REQ_SET_FREQ, REQ_SET_AMP, REQ_SET_PH, REQ_READ: begin
        if (!id_ok) st_c = ST_BAD_ID;
      end
      REQ_MODIFY: begin
        if (!id_ok)   st_c = ST_BAD_ID;
        else if (neg) st_c = ST_NEG;
      end
      REQ_COUNT, REQ_RST_CH: begin
        if (!ch_ok) st_c = ST_BAD_CH;
      end
      default: st_c = ST_OK;
    endcase
  end

  assign stat.remove_go  = (r_req == REQ_REMOVE) && id_ok;
  assign stat.shift_more = {1'b0, sh_k} < sh_n;

  // memory port control
  always_comb begin
    we_f  = 1'b0;
    we_a  = 1'b0;
    we_p  = 1'b0;
    waddr = {loc_ch, loc_idx};
    wd_f  = r_f;
    wd_a  = r_a;
    wd_p  = r_p;
    raddr = {loc_ch, loc_idx};
    if (cmd.shift_rd) raddr = {sh_c, sh_k + 1'b1};
    if (cmd.shift_wr) begin
      waddr = {sh_c, sh_k};
      wd_f  = rd_f;
      wd_a  = rd_a;
      wd_p  = rd_p;
      we_f  = 1'b1;
      we_a  = 1'b1;
      we_p  = 1'b1;
    end else if (cmd.exec && st_c == ST_OK) begin
      case (r_req)
        REQ_ADD: begin
          waddr = {ch_ix, n_ch[IDX_W-1:0]};
          we_f  = 1'b1;
          we_a  = 1'b1;
          we_p  = 1'b1;
        end
        REQ_MODIFY: begin
          we_f = 1'b1;
          we_a = 1'b1;
          we_p = 1'b1;
        end
        REQ_SET_FREQ: we_f = 1'b1;
        REQ_SET_AMP:  we_a = 1'b1;
        REQ_SET_PH:   we_p = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_f) mem_f[waddr] <= wd_f;
    if (we_a) mem_a[waddr] <= wd_a;
    if (we_p) mem_p[waddr] <= wd_p;
    rd_f <= mem_f[raddr];
    rd_a <= mem_a[raddr];
    rd_p <= mem_p[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      r_req <= req_type;
      r_id  <= wave_id;
      r_ch  <= channel;
      r_f   <= freq_in;
      r_a   <= amp_in;
      r_p   <= phase_in;
    end
    if (cmd.exec) begin
      res_st  <= st_c;
      res_id  <= (r_req == REQ_ADD && st_c == ST_OK) ? IDO_W'(free_id) : '0;
      res_cnt <= (r_req == REQ_COUNT && st_c == ST_OK) ? CNTO_W'(n_ch) : '0;
      res_rd  <= (r_req == REQ_READ) && (st_c == ST_OK);
      sh_c    <= loc_ch;
      sh_k    <= loc_idx;
      sh_n    <= n_rm;
    end
    if (cmd.shift_wr) sh_k <= sh_k + 1'b1;
    if (cmd.load_res) begin
      status     <= res_st;
      id_out     <= res_id;
      wave_count <= res_cnt;
      freq_out   <= res_rd ? rd_f : '0;
      amp_out    <= res_rd ? rd_a : '0;
      phase_out  <= res_rd ? rd_p : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WAVES; i++) map_v[i] <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) cnt[c] <= '0;
    end else if (cmd.exec && st_c == ST_OK) begin
      case (r_req)
        REQ_ADD: begin
          map_v[free_id]   <= 1'b1;
          map_ch[free_id]  <= ch_ix;
          map_idx[free_id] <= n_ch[IDX_W-1:0];
          cnt[ch_ix]       <= n_ch + 1'b1;
        end
        REQ_REMOVE: begin
          for (int i = 0; i < MAX_WAVES; i++) begin
            if (map_v[i] && map_ch[i] == loc_ch && map_idx[i] > loc_idx)
              map_idx[i] <= map_idx[i] - 1'b1;
          end
          map_v[id_ix] <= 1'b0;
          cnt[loc_ch]  <= n_rm;
        end
        REQ_RST_CH: begin
          for (int i = 0; i < MAX_WAVES; i++) begin
            if (map_ch[i] == ch_ix) map_v[i] <= 1'b0;
          end
          cnt[ch_ix] <= '0;
        end
        REQ_RST_ALL: begin
          for (int i = 0; i < MAX_WAVES; i++) map_v[i] <= 1'b0;
          for (int c = 0; c < NUM_CH; c++) cnt[c] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/wave_slot_table_top.sv =====
// sequencing: after acceptance a request passes through the EXEC and RESULT states
//   before the result is valid; a remove also passes SHIFT_CHK, then SHIFT_RD, SHIFT_WR
//   and SHIFT_CHK again per list entry moved (up to MAX_WAVES-1 entries)
// throughput: one request at a time, next accepted the cycle after the result
//   transaction; set by the sequencer handling a single request end to end
// reset: synchronous active-high rst clears the id map and channel counts;
//   no clearing pass, the block takes requests right after reset
module wave_slot_table_top import wst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // wave_id[4:0], channel[6:5], freq_in[22:7],
                                // amp_in[38:23], phase_in[54:39], zero pad
  input  logic [3:0]  s_tuser,  // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // status[2:0], id_out[6:3], freq_out[22:7],
                                // amp_out[38:23], phase_out[54:39],
                                // wave_count[59:55], zero pad
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  logic [ST_W-1:0]   status;
  logic [IDO_W-1:0]  id_out;
  logic [VAL_W-1:0]  freq_out, amp_out, phase_out;
  logic [CNTO_W-1:0] wave_count;

  // sequencer: accept, execute, walk the list on remove, present result
  wst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: id map, counts, parameter store and result register
  wst_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (s_tuser),
    .wave_id    (s_tdata[4:0]),
    .channel    (s_tdata[6:5]),
    .freq_in    (s_tdata[22:7]),
    .amp_in     (s_tdata[38:23]),
    .phase_in   (s_tdata[54:39]),
    .status     (status),
    .id_out     (id_out),
    .freq_out   (freq_out),
    .amp_out    (amp_out),
    .phase_out  (phase_out),
    .wave_count (wave_count)
  );

  // result transaction packing, top four bits padded with zeros
  assign m_tdata = {4'b0, wave_count, phase_out, amp_out, freq_out, id_out, status};

endmodule

// ===== dv/wave_slot_table_top_tb.sv =====
module wave_slot_table_top_tb;
  import wst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // request and result as seen on the streams
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [WID_W-1:0]  wid;
    logic [CHIN_W-1:0] ch;
    logic [VAL_W-1:0]  freq;
    logic [VAL_W-1:0]  amp;
    logic [VAL_W-1:0]  phase;
  } wave_req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDO_W-1:0]  id;
    logic [VAL_W-1:0]  freq;
    logic [VAL_W-1:0]  amp;
    logic [VAL_W-1:0]  phase;
    logic [CNTO_W-1:0] count;
  } wave_res_t;

  // one row of the directed table; chk marks a typed-in expectation
  typedef struct {
    wave_req_t r;
    logic      chk;
    wave_res_t e;
  } dir_row_t;

  localparam int WATCHDOG = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  wave_slot_table_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the table state
  logic [VAL_W-1:0]  sh_freq  [NUM_CH][MAX_WAVES];
  logic [VAL_W-1:0]  sh_amp   [NUM_CH][MAX_WAVES];
  logic [VAL_W-1:0]  sh_phase [NUM_CH][MAX_WAVES];
  logic              map_vld  [MAX_WAVES];
  int                map_ch   [MAX_WAVES];
  int                map_pos  [MAX_WAVES];
  int                ch_fill  [NUM_CH];

  wave_res_t exp_results[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        no_idle = 0;
  bit        hold_off = 0;

  function automatic void clear_shadow_ch(int c);
    for (int i = 0; i < MAX_WAVES; i++) begin
      sh_freq[c][i] = '0; sh_amp[c][i] = '0; sh_phase[c][i] = '0;
      if (map_vld[i] && map_ch[i] == c) map_vld[i] = 1'b0;
    end
    ch_fill[c] = 0;
  endfunction

  // works out the result of one request and updates the shadow table
  function automatic wave_res_t table_predict(wave_req_t r);
    wave_res_t o;
    bit        neg, id_good;
    int        c, k, n, total, fid;
    o = '0;
    neg = r.freq[VAL_W-1] | r.phase[VAL_W-1];
    id_good = (r.wid < MAX_WAVES) && map_vld[r.wid[3:0]];
    if (r.req >= REQ_REMOVE && r.req <= REQ_READ && !id_good) begin
      o.status = ST_BAD_ID;
      return o;
    end
    if (id_good) begin
      c = map_ch[r.wid[3:0]];
      k = map_pos[r.wid[3:0]];
    end
    case (r.req)
      REQ_ADD: begin
        if (r.ch >= NUM_CH) o.status = ST_BAD_CH;
        else if (neg) o.status = ST_NEG;
        else begin
          total = 0;
          for (int j = 0; j < NUM_CH; j++) total += ch_fill[j];
          fid = -1;
          for (int i = MAX_WAVES - 1; i >= 0; i--) if (!map_vld[i]) fid = i;
          if (total >= MAX_WAVES || fid < 0) o.status = ST_FULL;
          else begin
            n = ch_fill[r.ch];
            sh_freq[r.ch][n] = r.freq; sh_amp[r.ch][n] = r.amp;
            sh_phase[r.ch][n] = r.phase;
            ch_fill[r.ch] = n + 1;
            map_vld[fid] = 1'b1; map_ch[fid] = r.ch; map_pos[fid] = n;
            o.id = fid[IDO_W-1:0];
          end
        end
      end
      REQ_REMOVE: begin
        map_vld[r.wid[3:0]] = 1'b0;
        if (ch_fill[c] > 0) ch_fill[c]--;
        n = ch_fill[c];
        // close the gap and renumber the later waves
        for (int p = k; p < n && p + 1 < MAX_WAVES; p++) begin
          sh_freq[c][p] = sh_freq[c][p+1]; sh_amp[c][p] = sh_amp[c][p+1];
          sh_phase[c][p] = sh_phase[c][p+1];
          for (int i = 0; i < MAX_WAVES; i++)
            if (map_vld[i] && map_ch[i] == c && map_pos[i] == p + 1) begin
              map_pos[i] = p;
              break;
            end
        end
        for (int p = n; p < MAX_WAVES; p++) begin
          sh_freq[c][p] = '0; sh_amp[c][p] = '0; sh_phase[c][p] = '0;
        end
      end
      REQ_MODIFY: begin
        if (neg) o.status = ST_NEG;
        else begin
          sh_freq[c][k] = r.freq; sh_amp[c][k] = r.amp; sh_phase[c][k] = r.phase;
        end
      end
      REQ_SET_FREQ: sh_freq[c][k] = r.freq;
      REQ_SET_AMP:  sh_amp[c][k] = r.amp;
      REQ_SET_PH:   sh_phase[c][k] = r.phase;
      REQ_READ: begin
        o.freq = sh_freq[c][k]; o.amp = sh_amp[c][k]; o.phase = sh_phase[c][k];
      end
      REQ_COUNT: begin
        if (r.ch >= NUM_CH) o.status = ST_BAD_CH;
        else o.count = ch_fill[r.ch][CNTO_W-1:0];
      end
      REQ_RST_CH: begin
        if (r.ch >= NUM_CH) o.status = ST_BAD_CH;
        else clear_shadow_ch(r.ch);
      end
      REQ_RST_ALL: for (int j = 0; j < NUM_CH; j++) clear_shadow_ch(j);
      default: ;
    endcase
    return o;
  endfunction

  function automatic wave_req_t mk_req(logic [3:0] q, int w, int c, int f, int a, int p);
    wave_req_t r;
    r.req = q; r.wid = w[4:0]; r.ch = c[1:0];
    r.freq = f[15:0]; r.amp = a[15:0]; r.phase = p[15:0];
    return r;
  endfunction

  function automatic wave_res_t mk_res(logic [2:0] s, int i, int cnt);
    wave_res_t e;
    e = '0; e.status = s; e.id = i[3:0]; e.count = cnt[4:0];
    return e;
  endfunction

  // random request, mostly well formed so the table fills and drains
  function automatic wave_req_t rand_req();
    wave_req_t r;
    int        sel, live[$];
    r = mk_req(4'($urandom_range(0, 9)), $urandom_range(0, 31), $urandom_range(0, 3),
               $urandom, $urandom, $urandom);
    for (int i = 0; i < MAX_WAVES; i++) if (map_vld[i]) live.push_back(i);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      r.req = REQ_ADD; r.ch = 2'($urandom_range(0, NUM_CH - 1));
      if ($urandom_range(0, 9) != 0) begin
        r.freq[15] = 1'b0; r.phase[15] = 1'b0;
      end
    end else if (sel < 90) begin
      if (r.req == REQ_RST_ALL && $urandom_range(0, 7) != 0) r.req = REQ_READ;
      if (r.req == REQ_RST_CH && $urandom_range(0, 3) != 0) r.req = REQ_REMOVE;
      if (live.size() > 0 && $urandom_range(0, 7) != 0)
        r.wid = 5'(live[$urandom_range(0, live.size() - 1)]);
      if (r.ch >= NUM_CH && $urandom_range(0, 3) != 0) r.ch[1] = 1'b0;
      if (r.req == REQ_MODIFY && $urandom_range(0, 4) != 0) begin
        r.freq[15] = 1'b0; r.phase[15] = 1'b0;
      end
    end else if (sel < 93) begin
      r.req = 4'($urandom_range(10, 15));
    end
    return r;
  endfunction

  dir_row_t dir_rows[$];

  task automatic send_req(wave_req_t r);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tdata  <= {1'b0, r.phase, r.amp, r.freq, r.ch, r.wid};
    s_tuser  <= r.req;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // predictions are made at acceptance time, in order
  always @(posedge clk) begin
    wave_req_t acc;
    if (!rst && s_tvalid && s_tready) begin
      acc = {s_tuser, s_tdata[4:0], s_tdata[6:5], s_tdata[22:7],
             s_tdata[38:23], s_tdata[54:39]};
      exp_results.push_back(table_predict(acc));
    end
  end

  // directed rows with typed-in expectations are checked on top of the predictor
  wave_res_t typed_exp[$];
  logic      typed_chk[$];

  always @(posedge clk) begin
    wave_res_t got, want;
    logic      tchk;
    wave_res_t texp;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[6:3], m_tdata[22:7], m_tdata[38:23],
             m_tdata[54:39], m_tdata[59:55]};
      if (exp_results.size() == 0) begin
        $display("%0t unexpected result transaction %h", $realtime, got);
        errors++;
      end else begin
        want = exp_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected st=%0d id=%0d f=%h a=%h p=%h n=%0d",
                   $realtime, want.status, want.id, want.freq, want.amp,
                   want.phase, want.count);
          $display("%0t           actual   st=%0d id=%0d f=%h a=%h p=%h n=%0d",
                   $realtime, got.status, got.id, got.freq, got.amp,
                   got.phase, got.count);
          errors++;
        end
      end
      if (typed_chk.size() > 0) begin
        tchk = typed_chk.pop_front();
        texp = typed_exp.pop_front();
        if (tchk && got !== texp) begin
          $display("%0t table row mismatch: expected %h actual %h",
                   $realtime, texp, got);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("wave_slot_table_top verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    // directed table: extremes, every request kind, each error path but ST_FULL
    dir_rows.push_back('{mk_req(REQ_COUNT, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1, mk_res(ST_BAD_ID, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_READ, 31, 3, 0, 0, 0), 1, mk_res(ST_BAD_ID, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 3, 0, 0, 0), 1, mk_res(ST_BAD_CH, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 2, 0, 0, 0), 1, mk_res(ST_BAD_CH, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 0, -1, 0, 0), 1, mk_res(ST_NEG, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 0, 0, 0, -32768), 1, mk_res(ST_NEG, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 31, 0, 32767, -32768, 32767), 1,
                         mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 1, 0, 32767, 0), 1, mk_res(ST_OK, 1, 0)});
    dir_rows.push_back('{mk_req(REQ_ADD, 0, 0, 1, 2, 3), 1, mk_res(ST_OK, 2, 0)});
    dir_rows.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk_req(REQ_COUNT, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 2)});
    dir_rows.push_back('{mk_req(REQ_COUNT, 0, 3, 0, 0, 0), 1, mk_res(ST_BAD_CH, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_MODIFY, 2, 0, 5, 6, -7), 1, mk_res(ST_NEG, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_MODIFY, 9, 0, 5, 6, 7), 1, mk_res(ST_BAD_ID, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_MODIFY, 2, 0, 5, 6, 7), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_SET_FREQ, 0, 0, -32768, 0, 0), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_SET_AMP, 1, 0, 0, -1, 0), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_SET_PH, 2, 0, 0, 0, -1), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_REMOVE, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_READ, 2, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk_req(4'd15, 31, 3, -1, -1, -1), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_RST_CH, 0, 2, 0, 0, 0), 1, mk_res(ST_BAD_CH, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_RST_CH, 0, 1, 0, 0, 0), 1, mk_res(ST_OK, 0, 0)});
    dir_rows.push_back('{mk_req(REQ_RST_ALL, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0)});

    for (int i = 0; i < MAX_WAVES; i++) map_vld[i] = 1'b0;
    for (int j = 0; j < NUM_CH; j++) clear_shadow_ch(j);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_chk.push_back(dir_rows[i].chk);
      typed_exp.push_back(dir_rows[i].e);
      send_req(dir_rows[i].r);
    end

    // random part; a long receiver hold-off partway through
    for (k = 0; k < 650; k++) begin
      if (k == 200) hold_off = 1;
      if (k == 560) no_idle = 1;
      send_req(rand_req());
    end
    s_tvalid <= 1'b0;

    while (exp_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("wave_slot_table_top verification clean");
    end else begin
      $display("wave_slot_table_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wst_pkg.sv
design/wst_ctrl.sv
design/wst_dp.sv
design/wave_slot_table_top.sv
dv/wave_slot_table_top_tb.sv
